// ===== rtl/smsd_pkg.sv =====
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared constants for the sliding median spike detector.
// ----------------------------------------------------------------------------
package smsd_pkg;

   localparam int WINDOW_MAX_DEF  = 256;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CFG_W           = 9;
   localparam int TOTAL_W         = 32;

endpackage

// ===== rtl/smsd_mem.sv =====
// ----------------------------------------------------------------------------
// smsd_mem
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module smsd_mem #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sliding_median_spike_detector.sv =====
// One transaction at a time. Each transaction scans the sorted-window memory
// through its single read port, once to remove the oldest sample (only once
// the window is full) and once to insert the new one.
// Reset (synchronous): sequencer idle, counters cleared, window_len = 1;
// the history and sorted memories are not cleared.
// ----------------------------------------------------------------------------
// sliding_median_spike_detector
// Tests each sample against the median of the trailing window (alert when the
// sample is at or above it), keeping the window sorted in memory under a sequencer.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector #(
   parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SAMPLE_BITS-1:0]       req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_alert,
   output logic                         rsp_window_ready,
   output logic [SAMPLE_BITS:0]         rsp_median_doubled,
   output logic [smsd_pkg::TOTAL_W-1:0] rsp_alert_total,
   input  logic                         csr_we,
   input  logic [smsd_pkg::CFG_W-1:0]   csr_wdata
);
   import smsd_pkg::*;

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (CFG_W > LEN_W) ? CFG_W : LEN_W;
   localparam int SUM_W = LEN_W + 1;
   localparam int MED_W = SAMPLE_BITS + 1;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_MED_HI   = 10'b0000000010,
      S_MED_LO   = 10'b0000000100,
      S_MED_CALC = 10'b0000001000,
      S_DEL_RD   = 10'b0000010000,
      S_DEL_WR   = 10'b0000100000,
      S_INS_RD   = 10'b0001000000,
      S_INS_WR   = 10'b0010000000,
      S_INS_LAST = 10'b0100000000,
      S_FIN      = 10'b1000000000
   } state_type;

   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         held_ff, held_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]   hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]   old_ff, old_in;
   logic [MED_W-1:0]         doubled_ff, doubled_in;
   logic                     alert_ff, alert_in;
   logic                     full_ff, full_in;
   logic                     found_ff, found_in;
   logic [LEN_W-1:0]         j_ff, j_in;
   logic [LEN_W-1:0]         k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_alert_ff, rsp_alert_in;
   logic                     rsp_full_ff, rsp_full_in;
   logic [MED_W-1:0]         rsp_med_ff, rsp_med_in;
   logic [TOTAL_W-1:0]       rsp_total_ff, rsp_total_in;

   logic                     srt_we;
   logic [IDX_W-1:0]         srt_waddr, srt_raddr;
   logic [SAMPLE_BITS-1:0]   srt_wdata, srt_rdata;
   logic                     ring_we;
   logic [IDX_W-1:0]         ring_raddr;
   logic [SAMPLE_BITS-1:0]   ring_rdata;

   logic [LEN_W-1:0]         half;
   logic [LEN_W-1:0]         lo_pos;
   logic [SUM_W-1:0]         old_sum;
   logic [SUM_W-1:0]         old_pos;
   logic [LEN_W-1:0]         j_m1;
   logic [LEN_W-1:0]         k_p1;
   logic [CMP_W-1:0]         cfg_val;
   logic [LEN_W-1:0]         cfg_len;
   logic                     out_free;
   logic                     in_fire;

   smsd_mem #(
      .DEPTH  (WINDOW_MAX),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   smsd_mem #(
      .DEPTH  (WINDOW_MAX),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (IDX_W)
   ) u_sorted (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_waddr),
      .wr_data (srt_wdata),
      .rd_addr (srt_raddr),
      .rd_data (srt_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign in_fire   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign half    = len_ff >> 1;
   assign lo_pos  = len_ff[0] ? half : (half - LEN_W'(1));
   assign old_sum = SUM_W'(slot_ff) + SUM_W'(WINDOW_MAX) - SUM_W'(len_ff);
   assign old_pos = (old_sum >= SUM_W'(WINDOW_MAX)) ? (old_sum - SUM_W'(WINDOW_MAX)) : old_sum;
   assign j_m1    = j_ff - LEN_W'(1);
   assign k_p1    = k_ff + LEN_W'(1);
   assign ring_raddr = old_pos[IDX_W-1:0];
   assign ring_we    = (state_ff == S_FIN) && out_free;

   assign cfg_val = CMP_W'(csr_wdata);
   always_comb begin
      cfg_len = cfg_val[LEN_W-1:0];
      if (cfg_val == '0) begin
         cfg_len = LEN_W'(1);
      end else if (cfg_val > CMP_W'(WINDOW_MAX)) begin
         cfg_len = LEN_W'(WINDOW_MAX);
      end
   end

   // sorted memory port control
   always_comb begin
      srt_we    = 1'b0;
      srt_waddr = '0;
      srt_wdata = sample_ff;
      srt_raddr = '0;
      unique case (state_ff)
         S_MED_HI: begin
            srt_raddr = half[IDX_W-1:0];
         end
         S_MED_LO: begin
            srt_raddr = lo_pos[IDX_W-1:0];
         end
         S_DEL_RD: begin
            srt_raddr = j_ff[IDX_W-1:0];
         end
         S_DEL_WR: begin
            srt_we    = found_ff;
            srt_waddr = j_m1[IDX_W-1:0];
            srt_wdata = srt_rdata;
         end
         S_INS_RD: begin
            srt_raddr = k_ff[IDX_W-1:0];
         end
         S_INS_WR: begin
            srt_we    = 1'b1;
            srt_waddr = k_p1[IDX_W-1:0];
            srt_wdata = (srt_rdata > sample_ff) ? srt_rdata : sample_ff;
         end
         S_INS_LAST: begin
            srt_we    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      held_in      = held_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      sample_in    = sample_ff;
      hi_in        = hi_ff;
      old_in       = old_ff;
      doubled_in   = doubled_ff;
      alert_in     = alert_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_alert_in = rsp_alert_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_total_in = rsp_total_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               sample_in  = req_sample;
               full_in    = (held_ff >= len_ff);
               alert_in   = 1'b0;
               doubled_in = '0;
               if (held_ff >= len_ff) begin
                  state_in = S_MED_HI;
               end else if (held_ff == '0) begin
                  state_in = S_INS_LAST;
               end else begin
                  k_in     = held_ff - LEN_W'(1);
                  state_in = S_INS_RD;
               end
            end
         end
         S_MED_HI: begin
            state_in = S_MED_LO;
         end
         S_MED_LO: begin
            hi_in    = srt_rdata;
            old_in   = ring_rdata;
            state_in = S_MED_CALC;
         end
         S_MED_CALC: begin
            if (len_ff[0]) begin
               doubled_in = {hi_ff, 1'b0};
            end else begin
               doubled_in = {1'b0, hi_ff} + {1'b0, srt_rdata};
            end
            alert_in = ({sample_ff, 1'b0} >= doubled_in);
            j_in     = '0;
            found_in = 1'b0;
            state_in = S_DEL_RD;
         end
         S_DEL_RD: begin
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            if (!found_ff && (srt_rdata == old_ff)) begin
               found_in = 1'b1;
            end
            j_in = j_ff + LEN_W'(1);
            if (j_ff == len_ff - LEN_W'(1)) begin
               if (len_ff == LEN_W'(1)) begin
                  state_in = S_INS_LAST;
               end else begin
                  k_in     = len_ff - LEN_W'(2);
                  state_in = S_INS_RD;
               end
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            if (srt_rdata > sample_ff) begin
               if (k_ff == '0) begin
                  state_in = S_INS_LAST;
               end else begin
                  k_in     = k_ff - LEN_W'(1);
                  state_in = S_INS_RD;
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_INS_LAST: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               if (alert_ff && (total_ff != {TOTAL_W{1'b1}})) begin
                  total_in = total_ff + TOTAL_W'(1);
               end
               if (LEN_W'(slot_ff) == LEN_W'(WINDOW_MAX - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + IDX_W'(1);
               end
               if (held_ff != LEN_W'(WINDOW_MAX)) begin
                  held_in = held_ff + LEN_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_alert_in = alert_ff;
               rsp_full_in  = full_ff;
               rsp_med_in   = doubled_ff;
               rsp_total_in = total_in;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         len_in  = cfg_len;
         held_in = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LEN_W'(1);
         held_ff      <= '0;
         slot_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         held_ff      <= held_in;
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      hi_ff        <= hi_in;
      old_ff       <= old_in;
      doubled_ff   <= doubled_in;
      alert_ff     <= alert_in;
      full_ff      <= full_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      rsp_alert_ff <= rsp_alert_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_med_ff   <= rsp_med_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alert          = rsp_alert_ff;
   assign rsp_window_ready   = rsp_full_ff;
   assign rsp_median_doubled = rsp_med_ff;
   assign rsp_alert_total    = rsp_total_ff;

endmodule

// ===== rtl/smsd_checker.sv =====
// ----------------------------------------------------------------------------
// smsd_checker
// Port-level checks for the sliding median spike detector, bound to the top.
// ----------------------------------------------------------------------------
module smsd_checker #(
   parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_alert,
   input logic                         rsp_window_ready,
   input logic [SAMPLE_BITS:0]         rsp_median_doubled,
   input logic [smsd_pkg::TOTAL_W-1:0] rsp_alert_total
);
   import smsd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alert_total))
      else $error("stalled result changed");

   a_alert_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alert |-> rsp_window_ready)
      else $error("alert without a full window");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_ready |-> rsp_median_doubled == '0)
      else $error("median reported while window filling");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while busy");

endmodule

bind sliding_median_spike_detector smsd_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_smsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_alert          (rsp_alert),
   .rsp_window_ready   (rsp_window_ready),
   .rsp_median_doubled (rsp_median_doubled),
   .rsp_alert_total    (rsp_alert_total)
);
